@@ rtl/sorted_lru_learning_table_assert.svh @@
// Assertion macros for the sorted LRU learning table.
// Used by the top level; expects clk and rst in scope.
`ifndef SORTED_LRU_LEARNING_TABLE_ASSERT_SVH
`define SORTED_LRU_LEARNING_TABLE_ASSERT_SVH

// Same-cycle implication check
`define SLLT_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("sllt: same-cycle check failed");

// Next-cycle implication check
`define SLLT_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("sllt: next-cycle check failed");

`endif

@@ rtl/sllt_pkg.sv @@
// Package for the sorted LRU learning table: sizes, entry layout, codes, helpers.
// No dependencies.
`default_nettype none

package sllt_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int SWP_W       = CNT_W + 1;
  localparam int RANK_W      = 9;
  localparam logic [RANK_W-1:0] RANK_MAX = '1;

  localparam logic OP_LEARN  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [1:0] REG_ADDR_STORE_EN = 2'd0;

  typedef enum logic [2:0] {
    STAT_NORMAL      = 3'd0,
    STAT_EVICTED     = 3'd1,
    STAT_NOT_STUDIED = 3'd2,
    STAT_NO_STORE    = 3'd3,
    STAT_ERROR       = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_PREP,
    S_REWRITE,
    S_DONE
  } fsm_t;

  typedef struct packed {
    logic [15:0]       seg;
    logic [15:0]       ofs;
    logic [7:0]        dic;
    logic [RANK_W-1:0] rank;
    logic [7:0]        kj;
    logic [7:0]        ka;
    logic [7:0]        fl;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Age a rank by one, saturating at the top
  function automatic logic [RANK_W-1:0] age(input logic [RANK_W-1:0] r);
    age = (r == RANK_MAX) ? RANK_MAX : r + 1'b1;
  endfunction

  // Stored (seg, ofs) sorts at or before the new one
  function automatic logic key_le(input logic [15:0] eseg, input logic [15:0] eofs,
                                  input logic [15:0] nseg, input logic [15:0] nofs);
    key_le = (eseg < nseg) || ((eseg == nseg) && (eofs <= nofs));
  endfunction

endpackage

`default_nettype wire

@@ rtl/sorted_lru_learning_table.sv @@
// Sorted LRU learning table: top level with control sequencer and config port.
// Depends on sllt_pkg, sllt_ram and sorted_lru_learning_table_assert.svh.
//
// Usage: items enter on the in channel (in_valid / in_stall) and one result
// item leaves on the out channel (out_valid / out_stall) per input item.
// All entries live in one RAM with a registered read port. An item passes through:
//   - store disabled or learn with zero offset: straight to S_DONE;
//   - lookup: a search sweep over the stored entries, then S_PREP and S_DONE;
//   - learn: the search sweep, S_PREP, then a rewrite sweep in which every
//     entry is read, aged or shifted as needed and written back, then S_DONE.
// With a full table the sweeps over the RAM port set how long a learn item takes.
// in_stall is high while an item is in progress.
// The result sits in an output register; a new item is taken while it waits,
// and the sequencer holds its finished result until the register is free.
// Reset empties the table (count 0, no clearing pass) and sets store_enabled.
// Users write store_enabled (APB byte address 0) only while idle; not enforced.
`default_nettype none
`include "sorted_lru_learning_table_assert.svh"

module sorted_lru_learning_table
  import sllt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // APB configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // Input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        op,
  input  wire logic [15:0] key_segment,
  input  wire logic [15:0] key_offset,
  input  wire logic [7:0]  dict_id,
  input  wire logic        kanji_attr_valid,
  input  wire logic [7:0]  kanji_attr,
  input  wire logic        kana_attr_valid,
  input  wire logic [7:0]  kana_attr,
  input  wire logic [7:0]  flag_bits,
  // Output channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       status,
  output logic             found,
  output logic [8:0]       hit_rank,
  output logic [7:0]       hit_kanji_attr,
  output logic [7:0]       hit_kana_attr,
  output logic [7:0]       hit_flags
);

  fsm_t state, state_next;

  logic             store_en;
  logic [CNT_W-1:0] count;
  logic [SWP_W-1:0] sweep;

  // Held item
  logic        it_op;
  logic [15:0] it_seg, it_ofs;
  logic [7:0]  it_dic, it_kj, it_ka, it_fl;
  logic        it_kjv, it_kav;

  // Search results
  logic              hit;
  logic [ADDR_W-1:0] hit_idx;
  entry_t            hit_e;
  logic [CNT_W-1:0]  pos_pre;
  logic [RANK_W-1:0] best;
  logic [ADDR_W-1:0] victim;

  // Rewrite plan
  logic             ins, evict;
  logic [CNT_W-1:0] posn, newcount;

  // Pending result
  logic [2:0]  res_status;
  logic        res_found;
  logic [8:0]  res_rank;
  logic [7:0]  res_kj, res_ka, res_fl;

  // RAM interface and read history
  entry_t            rdata, b1, b2, wdata;
  logic              mem_we;
  logic [ADDR_W-1:0] waddr, raddr;

  // Control strobes
  logic accept, load_out, cfg_wr;

  // Datapath helpers
  logic [SWP_W-1:0]  srch_full, wr_full;
  logic [ADDR_W-1:0] srch_idx;
  logic [CNT_W-1:0]  wr_jc, src_o, src_x;
  logic [RANK_W-1:0] aged_rd;
  entry_t            src_e, new_e;

  sllt_ram #(.DEPTH(TABLE_DEPTH), .WIDTH(ENTRY_W)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Configuration register
  assign pready = 1'b1;
  assign prdata = {31'b0, store_en};
  assign cfg_wr = psel && penable && pwrite && (paddr == REG_ADDR_STORE_EN);

  always_ff @(posedge clk) begin
    if (rst) begin
      store_en <= 1'b1;
    end else if (cfg_wr) begin
      store_en <= pwdata[0];
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (!store_en || (op == OP_LEARN && key_offset == 16'd0)) state_next = S_DONE;
          else state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (sweep == {1'b0, count}) state_next = S_PREP;
      end
      S_PREP: begin
        state_next = (it_op == OP_LOOKUP) ? S_DONE : S_REWRITE;
      end
      S_REWRITE: begin
        if (sweep == ({1'b0, newcount} + 1'b1)) state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || !out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_stall = 1'b1;
    load_out = 1'b0;
    mem_we   = 1'b0;
    unique case (state)
      S_IDLE:    in_stall = 1'b0;
      S_SEARCH:  ;
      S_PREP:    ;
      S_REWRITE: mem_we   = (sweep >= SWP_W'(2));
      S_DONE:    load_out = !out_valid || !out_stall;
      default:   ;
    endcase
  end

  assign accept = in_valid && !in_stall;
  assign raddr  = sweep[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sweep counter: restart on entry to each sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep <= '0;
    end else if ((state == S_SEARCH || state == S_REWRITE) && state_next == state) begin
      sweep <= sweep + 1'b1;
    end else begin
      sweep <= '0;
    end
  end

  // Capture the item
  always_ff @(posedge clk) begin
    if (accept) begin
      it_op  <= op;
      it_seg <= key_segment;
      it_ofs <= key_offset;
      it_dic <= dict_id;
      it_kjv <= kanji_attr_valid;
      it_kj  <= kanji_attr;
      it_kav <= kana_attr_valid;
      it_ka  <= kana_attr;
      it_fl  <= flag_bits;
    end
  end

  // Search sweep: match, insert position and eviction victim
  assign srch_full = sweep - 1'b1;
  assign srch_idx  = srch_full[ADDR_W-1:0];
  assign aged_rd   = age(rdata.rank);

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (accept) begin
      hit <= 1'b0;
    end else if (state == S_SEARCH && sweep != '0 && !hit &&
                 rdata.seg == it_seg && rdata.ofs == it_ofs && rdata.dic == it_dic &&
                 it_ofs != 16'd0) begin
      hit <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pos_pre <= '0;
      best    <= '0;
      victim  <= '0;
    end else if (state == S_SEARCH && sweep != '0) begin
      if (!hit && rdata.seg == it_seg && rdata.ofs == it_ofs && rdata.dic == it_dic) begin
        hit_idx <= srch_idx;
        hit_e   <= rdata;
      end
      if (key_le(rdata.seg, rdata.ofs, it_seg, it_ofs)) pos_pre <= pos_pre + 1'b1;
      if (aged_rd > best) begin
        best   <= aged_rd;
        victim <= srch_idx;
      end
    end
  end

  // Plan the rewrite and form the result
  always_ff @(posedge clk) begin
    if (accept) begin
      res_status <= STAT_NORMAL;
      res_found  <= 1'b0;
      res_rank   <= '0;
      res_kj     <= '0;
      res_ka     <= '0;
      res_fl     <= '0;
      if (!store_en) res_status <= STAT_NO_STORE;
      else if (op == OP_LEARN && key_offset == 16'd0) res_status <= STAT_NOT_STUDIED;
    end else if (state == S_PREP) begin
      ins      <= !hit;
      evict    <= !hit && (count == CNT_W'(TABLE_DEPTH));
      posn     <= pos_pre - CNT_W'(!hit && (count == CNT_W'(TABLE_DEPTH)) &&
                                   (CNT_W'(victim) < pos_pre));
      newcount <= hit ? count : count + 1'b1 - CNT_W'(count == CNT_W'(TABLE_DEPTH));
      if (hit) begin
        res_found <= 1'b1;
        res_rank  <= hit_e.rank;
        if (it_op == OP_LOOKUP) begin
          res_kj <= hit_e.kj;
          res_ka <= hit_e.ka;
          res_fl <= hit_e.fl;
        end else begin
          res_kj <= it_kjv ? it_kj : hit_e.kj;
          res_ka <= it_kav ? it_ka : hit_e.ka;
          res_fl <= it_fl;
        end
      end else if (it_op == OP_LEARN && count == CNT_W'(TABLE_DEPTH)) begin
        res_status <= STAT_EVICTED;
      end
    end
  end

  // Rewrite sweep: write slot j = sweep-2 from old slot j-1, j or j+1
  assign wr_full = sweep - SWP_W'(2);
  assign wr_jc   = wr_full[CNT_W-1:0];
  assign waddr   = wr_full[ADDR_W-1:0];
  assign src_o   = (ins && wr_jc > posn) ? wr_jc - 1'b1 : wr_jc;
  assign src_x   = src_o + CNT_W'(evict && src_o >= CNT_W'(victim));

  always_comb begin
    new_e      = '0;
    new_e.seg  = it_seg;
    new_e.ofs  = it_ofs;
    new_e.dic  = it_dic;
    new_e.rank = RANK_W'(1);
    new_e.kj   = it_kjv ? it_kj : 8'd0;
    new_e.ka   = it_kav ? it_ka : 8'd0;
    new_e.fl   = it_fl;

    if (src_x < wr_jc) src_e = b2;
    else if (src_x == wr_jc) src_e = b1;
    else src_e = rdata;

    wdata = src_e;
    if (ins && wr_jc == posn) begin
      wdata = new_e;
    end else if (ins) begin
      wdata.rank = age(src_e.rank);
    end else if (src_x == CNT_W'(hit_idx)) begin
      wdata.rank = RANK_W'(1);
      if (it_kjv) wdata.kj = it_kj;
      if (it_kav) wdata.ka = it_ka;
      wdata.fl = it_fl;
    end else if (src_e.rank < hit_e.rank) begin
      wdata.rank = age(src_e.rank);
    end
  end

  // Keep the last two entries read
  always_ff @(posedge clk) begin
    b1 <= rdata;
    b2 <= b1;
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (state == S_REWRITE && state_next == S_DONE) begin
      count <= newcount;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status         <= res_status;
      found          <= res_found;
      hit_rank       <= res_rank;
      hit_kanji_attr <= res_kj;
      hit_kana_attr  <= res_ka;
      hit_flags      <= res_fl;
    end
  end

  `SLLT_ASSERT_IMP(a_we_in_rewrite, mem_we, state == S_REWRITE)
  `SLLT_ASSERT_IMP(a_we_below_count, mem_we, wr_jc < newcount)
  `SLLT_ASSERT_NXT(a_accept_leaves_idle, accept, state != S_IDLE)
  `SLLT_ASSERT_IMP(a_count_bounded, state == S_DONE, count <= CNT_W'(TABLE_DEPTH))

endmodule

`default_nettype wire

@@ rtl/sllt_ram.sv @@
// Simple dual-port synchronous RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module sllt_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
